### design/power_reading_scale_tare_bcd_macros.svh
// Assertion macros shared by the reading block.
`ifndef POWER_READING_SCALE_TARE_BCD_MACROS_SVH
`define POWER_READING_SCALE_TARE_BCD_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PRSTB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prstb check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define PRSTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prstb check failed");

`endif

### design/prstb_pkg.sv
`default_nettype none
package prstb_pkg;

	// converter width; codes are masked to it and then to the 16-bit field
	localparam int ADC_WIDTH = 16;
	localparam logic [15:0] CODE_MASK = (ADC_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << ADC_WIDTH) - 32'd1);

	// coefficient reset values (Q16)
	localparam logic [15:0] MV_COEF_RST = 16'd5370;
	localparam logic [15:0] MW_COEF_RST = 16'd49939;

	// register indexes
	localparam logic CFG_MV_COEF = 1'b0;
	localparam logic CFG_MW_COEF = 1'b1;

	// bias that turns an arithmetic shift into truncation toward zero
	localparam logic signed [33:0] TRUNC_BIAS = 34'sd65535;

	typedef struct packed {
		logic [15:0] adc_code;
		logic        tare_pressed;
	} in_word_t;

	typedef struct packed {
		logic signed [16:0] power_tenths;
		logic [15:0]        voltage_tenths;
		logic [19:0]        power_bcd;
		logic [19:0]        voltage_bcd;
	} out_word_t;

endpackage
`default_nettype wire

### design/prstb_bcd_step8.sv
`default_nettype none
// Eight shift-add-3 steps of a binary to packed BCD conversion.
// Bits enter MSB first below the running five-digit value.
module prstb_bcd_step8 (
	input  logic [19:0] bcd_in,
	input  logic [7:0]  bits_in,
	output logic [19:0] bcd_out
);

	logic [19:0] acc;

	always_comb begin
		acc = bcd_in;
		for (int i = 0; i < 8; i++) begin
			// digits of 5 or more get 3 added so the shift carries correctly
			for (int d = 0; d < 5; d++) begin
				if (acc[4*d +: 4] >= 4'd5) begin
					acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
				end
			end
			acc = {acc[18:0], bits_in[7-i]};
		end
		bcd_out = acc;
	end

endmodule
`default_nettype wire

### design/power_reading_scale_tare_bcd.sv
`default_nettype none
// Channel   Handshake                 Word
// in        in_valid / in_ready       in_word  (adc_code, tare_pressed)
// out       out_valid / out_ready     out_word (power, voltage, both BCD)
// cfg       cfg_we, cfg_index         cfg_data (mv_coef, mw_coef)
//
// Five-stage pipeline: tare subtract, multiplies, rounding toward zero,
// then two halves of the BCD conversion. One word per cycle while the output
// is not stalled; the result is offered from the stage 5 output register.
// Each stage holds its word while the one after it is full and stalled;
// empty stages keep filling, so input stays open behind a waiting result.
// Reset clears the valid bits and the tare (0), and loads the coefficient defaults.
module power_reading_scale_tare_bcd (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  prstb_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output prstb_pkg::out_word_t out_word,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data
);

	logic [15:0] mv_coef_q, mw_coef_q, tare_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic [15:0]        code_in;
	logic               in_acc;
	logic signed [16:0] diff_s1;
	logic [15:0]        code_s1;

	logic [31:0]        vprod;
	logic signed [33:0] pprod;
	logic [15:0]        volt_s2;
	logic signed [33:0] pprod_s2;

	logic signed [33:0] pbias;
	logic signed [16:0] pw;
	logic signed [16:0] pw_s3;
	logic [15:0]        volt_s3, mag_s3;

	logic [19:0]        pbcd_hi, vbcd_hi;
	logic signed [16:0] pw_s4;
	logic [15:0]        volt_s4;
	logic [7:0]         mag_lo_s4;
	logic [19:0]        pbcd_s4, vbcd_s4;

	logic [19:0]        pbcd_full, vbcd_full;
	prstb_pkg::out_word_t out_s5;

	// per-stage ready: a stage takes a word when empty or draining
	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_coef_q <= prstb_pkg::MV_COEF_RST;
			mw_coef_q <= prstb_pkg::MW_COEF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				prstb_pkg::CFG_MV_COEF: mv_coef_q <= cfg_data;
				prstb_pkg::CFG_MW_COEF: mw_coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tare: the word is measured against the old tare, then captured
	assign code_in = in_word.adc_code & prstb_pkg::CODE_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= 16'd0;
		end else if (in_acc && in_word.tare_pressed) begin
			tare_q <= code_in;
		end
	end

	// stage 1: tared difference
	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_s1 <= code_in;
			diff_s1 <= $signed({1'b0, code_in}) - $signed({1'b0, tare_q});
		end
	end

	// stage 2: the two multiplies
	assign vprod = {16'd0, code_s1} * {16'd0, mv_coef_q};
	assign pprod = 34'(diff_s1) * 34'($signed({1'b0, mw_coef_q}));

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			volt_s2  <= vprod[31:16];
			pprod_s2 <= pprod;
		end
	end

	// stage 3: divide power by 65536 toward zero, take magnitude
	assign pbias = pprod_s2 + (pprod_s2[33] ? prstb_pkg::TRUNC_BIAS : 34'sd0);
	assign pw    = pbias[32:16];

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			pw_s3   <= pw;
			volt_s3 <= volt_s2;
			mag_s3  <= pw[16] ? 16'(-pw) : pw[15:0];
		end
	end

	// stage 4: BCD of the high bytes
	prstb_bcd_step8 u_pbcd_hi (.bcd_in(20'd0), .bits_in(mag_s3[15:8]), .bcd_out(pbcd_hi));
	prstb_bcd_step8 u_vbcd_hi (.bcd_in(20'd0), .bits_in(volt_s3[15:8]), .bcd_out(vbcd_hi));

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			pw_s4     <= pw_s3;
			volt_s4   <= volt_s3;
			mag_lo_s4 <= mag_s3[7:0];
			pbcd_s4   <= pbcd_hi;
			vbcd_s4   <= vbcd_hi;
		end
	end

	// stage 5: finish BCD with the low bytes, output register
	prstb_bcd_step8 u_pbcd_lo (.bcd_in(pbcd_s4), .bits_in(mag_lo_s4), .bcd_out(pbcd_full));
	prstb_bcd_step8 u_vbcd_lo (.bcd_in(vbcd_s4), .bits_in(volt_s4[7:0]), .bcd_out(vbcd_full));

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_s5) begin
			out_s5.power_tenths   <= pw_s4;
			out_s5.voltage_tenths <= volt_s4;
			out_s5.power_bcd      <= pbcd_full;
			out_s5.voltage_bcd    <= vbcd_full;
		end
	end

	assign out_valid = v_s5;
	assign out_word  = out_s5;

`include "power_reading_scale_tare_bcd_macros.svh"

	// a tare press takes the accepted code
	`PRSTB_ASSERT_NEXT(a_tare_capture, in_acc && in_word.tare_pressed, tare_q == $past(code_in))
	// the tare only moves on a tare press
	`PRSTB_ASSERT_NEXT(a_tare_hold, !(in_acc && in_word.tare_pressed), $stable(tare_q))
	// a full stage 4 behind a stalled output keeps its word
	`PRSTB_ASSERT_NEXT(a_s4_hold, v_s4 && !rdy_s5, v_s4 && $stable(pbcd_s4) && $stable(volt_s4))
	// sixteen-bit magnitudes never reach a leading digit above six
	`PRSTB_ASSERT_NOW(a_bcd_top, out_valid, out_word.power_bcd[19:16] <= 4'd6 && out_word.voltage_bcd[19:16] <= 4'd6)

endmodule
`default_nettype wire
